// ===== rtl/battery_charge_controller_defines.svh =====
// ----------------------------------------------------------------------------
// battery charge controller assertion macros
// shared property macros for the charger rtl
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_CONTROLLER_DEFINES_SVH
`define BATTERY_CHARGE_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("charger assertion failed");

// next-cycle implication
`define BCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("charger assertion failed");

`else

`define BCC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BCC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// types and constants of the battery charge controller
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int FILTER_DEPTH = 32;
   localparam int SAMPLE_BITS  = 12;
   localparam int RING_AW      = $clog2(FILTER_DEPTH);
   localparam int SUM_W        = SAMPLE_BITS + RING_AW;
   localparam int CFG_W        = 16;
   localparam int CSR_IDX_W    = 3;

   localparam logic [15:0] OVERCURRENT_WAIT = 16'd2;

   // opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VBAT_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_LIM  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSAL_LVL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_ON      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_HOLD    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSAL_MS  = 3'd6;

   // register reset values
   localparam logic [11:0] RST_VBAT_MIN     = 12'd500;
   localparam logic [11:0] RST_CURRENT_LIM  = 12'd3000;
   localparam logic [11:0] RST_REVERSAL_LVL = 12'd100;
   localparam logic [11:0] RST_SYNC_ON      = 12'd2200;
   localparam logic [11:0] RST_SYNC_LOW     = 12'd1800;
   localparam logic [15:0] RST_FULL_HOLD    = 16'd60;
   localparam logic [15:0] RST_REVERSAL_MS  = 16'd5000;

   typedef enum logic [1:0] {
      MODE_STANDBY     = 2'd0,
      MODE_CHARGING    = 2'd1,
      MODE_OVERCURRENT = 2'd2,
      MODE_REVERSAL    = 2'd3
   } mode_type;

endpackage

// ===== rtl/bcc_if.sv =====
// ----------------------------------------------------------------------------
// bcc channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bcc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [11:0] line_sample;
   logic [11:0] battery_sample;
   logic [11:0] current_sample;
   logic [11:0] setpoint_sample;

   modport source (output valid, opcode, line_sample, battery_sample,
                   current_sample, setpoint_sample, input ready);
   modport sink   (input valid, opcode, line_sample, battery_sample,
                   current_sample, setpoint_sample, output ready);
endinterface

interface bcc_rsp_if;
   logic       valid;
   logic       ready;
   logic       switch_on;
   logic       sync_out;
   logic [1:0] charger_state;
   logic       error_code;
   logic       charging_lamp;
   logic       fault_lamp;

   modport source (output valid, switch_on, sync_out, charger_state, error_code,
                   charging_lamp, fault_lamp, input ready);
   modport sink   (input valid, switch_on, sync_out, charger_state, error_code,
                   charging_lamp, fault_lamp, output ready);
endinterface

// ===== rtl/battery_charge_controller.sv =====
// ----------------------------------------------------------------------------
// battery_charge_controller
// charger control: filtered battery/setpoint, charge state machine, line sync
// ----------------------------------------------------------------------------
// Each request transaction is either an adc sample set or a millisecond tick,
// and each one yields exactly one response transaction with the output
// snapshot after it. The block takes one transaction per clock while the
// response side is not stalled; a request is captured into the stage 1
// registers, then updated into the response register. The battery and setpoint
// rings share one 32-entry synchronous memory; its registered read sets the
// two-stage split. Ring entries carry a valid bit each, so there is no
// clearing pass after reset. Configuration writes go through the csr port
// and are meant to happen while no transaction is in flight.
`include "battery_charge_controller_defines.svh"

module battery_charge_controller (
   input  logic                           clock,
   input  logic                           reset,
   bcc_req_if.sink                        req_ch,
   bcc_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcc_pkg::CFG_W-1:0]      csr_wr_data
);

   localparam int SB = bcc_pkg::SAMPLE_BITS;
   localparam int AW = bcc_pkg::RING_AW;
   localparam int SW = bcc_pkg::SUM_W;
   localparam logic [AW-1:0] POS_LAST = AW'(bcc_pkg::FILTER_DEPTH - 1);

   // configuration registers
   logic [11:0] vbat_min_ff, current_lim_ff, reversal_lvl_ff;
   logic [11:0] sync_on_ff, sync_low_ff;
   logic [15:0] full_hold_ff, reversal_ms_ff;

   // ring memory: {setpoint, battery} per entry
   logic [2*SB-1:0]                    ring_mem [bcc_pkg::FILTER_DEPTH];
   logic [2*SB-1:0]                    ring_rd_ff;
   logic [bcc_pkg::FILTER_DEPTH-1:0]   ring_vld_ff;
   logic                               ring_hit_ff;
   logic [AW-1:0]                      pos_ff;

   // stage 1 holding register
   logic          s1_valid_ff;
   logic          s1_op_ff;
   logic [SB-1:0] s1_line_ff, s1_vb_ff, s1_ipk_ff, s1_vs_ff;
   logic [AW-1:0] s1_pos_ff;

   // controller state
   bcc_pkg::mode_type mode_ff, mode_in;
   logic [SW-1:0] bat_sum_ff, bat_sum_in, set_sum_ff, set_sum_in;
   logic [15:0]   full_ff, full_in, wait_ff, wait_in;
   logic          sync_lvl_ff, sync_lvl_in, sync_edge_ff, sync_edge_in;
   logic          switch_ff, switch_in;
   logic          yellow_ff, yellow_in, red_ff, red_in, err_ff, err_in;

   // response register
   logic          rsp_valid_ff;

   // handshake
   logic          adv;
   logic          req_fire;
   logic          rd_en;
   logic          s1_fire;
   logic          s1_wr;

   logic [SB-1:0] old_bat, old_set;
   logic [SB-1:0] vbat, vset;

   assign adv      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || adv;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rd_en    = req_fire && (req_ch.opcode == bcc_pkg::OP_SAMPLE);
   assign s1_fire  = s1_valid_ff && adv;
   assign s1_wr    = s1_fire && (s1_op_ff == bcc_pkg::OP_SAMPLE);

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vbat_min_ff     <= bcc_pkg::RST_VBAT_MIN;
         current_lim_ff  <= bcc_pkg::RST_CURRENT_LIM;
         reversal_lvl_ff <= bcc_pkg::RST_REVERSAL_LVL;
         sync_on_ff      <= bcc_pkg::RST_SYNC_ON;
         sync_low_ff     <= bcc_pkg::RST_SYNC_LOW;
         full_hold_ff    <= bcc_pkg::RST_FULL_HOLD;
         reversal_ms_ff  <= bcc_pkg::RST_REVERSAL_MS;
      end else if (csr_wr_en) begin
         case (csr_index)
            bcc_pkg::CSR_VBAT_MIN:     vbat_min_ff     <= csr_wr_data[11:0];
            bcc_pkg::CSR_CURRENT_LIM:  current_lim_ff  <= csr_wr_data[11:0];
            bcc_pkg::CSR_REVERSAL_LVL: reversal_lvl_ff <= csr_wr_data[11:0];
            bcc_pkg::CSR_SYNC_ON:      sync_on_ff      <= csr_wr_data[11:0];
            bcc_pkg::CSR_SYNC_LOW:     sync_low_ff     <= csr_wr_data[11:0];
            bcc_pkg::CSR_FULL_HOLD:    full_hold_ff    <= csr_wr_data;
            bcc_pkg::CSR_REVERSAL_MS:  reversal_ms_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // stage 0: ring read at the write pointer, capture the transaction
   // consecutive samples touch neighboring entries, so the stage 1 write
   // never hits the address read in the same cycle
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rd_en) begin
         ring_rd_ff <= ring_mem[pos_ff];
      end
      if (s1_wr) begin
         ring_mem[s1_pos_ff] <= {s1_vs_ff, s1_vb_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         pos_ff      <= '0;
      end else begin
         if (s1_wr) begin
            ring_vld_ff[s1_pos_ff] <= 1'b1;
         end
         if (rd_en) begin
            pos_ff <= (pos_ff == POS_LAST) ? '0 : pos_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_ch.opcode;
         s1_line_ff  <= req_ch.line_sample;
         s1_vb_ff    <= req_ch.battery_sample;
         s1_ipk_ff   <= req_ch.current_sample;
         s1_vs_ff    <= req_ch.setpoint_sample;
         s1_pos_ff   <= pos_ff;
         ring_hit_ff <= ring_vld_ff[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: filter update, charge state machine, line sync
   // ---------------------------------------------------------------------
   // entries never written read as zero
   assign old_bat = ring_hit_ff ? ring_rd_ff[SB-1:0]    : '0;
   assign old_set = ring_hit_ff ? ring_rd_ff[2*SB-1:SB] : '0;

   always_comb begin
      mode_in      = mode_ff;
      bat_sum_in   = bat_sum_ff;
      set_sum_in   = set_sum_ff;
      full_in      = full_ff;
      wait_in      = wait_ff;
      sync_lvl_in  = sync_lvl_ff;
      sync_edge_in = sync_edge_ff;
      switch_in    = switch_ff;
      yellow_in    = yellow_ff;
      red_in       = red_ff;
      err_in       = err_ff;

      // running sums, average is the top bits
      bat_sum_in = bat_sum_ff - SW'(old_bat) + SW'(s1_vb_ff);
      set_sum_in = set_sum_ff - SW'(old_set) + SW'(s1_vs_ff);
      vbat       = bat_sum_in[SW-1:AW];
      vset       = set_sum_in[SW-1:AW];

      if (s1_op_ff == bcc_pkg::OP_TICK) begin
         // tick only runs the fault timer
         bat_sum_in = bat_sum_ff;
         set_sum_in = set_sum_ff;
         if (wait_ff != '0) begin
            wait_in = wait_ff - 16'd1;
         end
      end else begin
         case (mode_ff)
            bcc_pkg::MODE_STANDBY: begin
               switch_in = 1'b0;
               if (vbat > vbat_min_ff && vbat < vset) begin
                  mode_in = bcc_pkg::MODE_CHARGING;
               end
               if (s1_vb_ff < reversal_lvl_ff) begin
                  mode_in = bcc_pkg::MODE_REVERSAL;
                  err_in  = 1'b1;
                  wait_in = reversal_ms_ff;
               end
            end
            bcc_pkg::MODE_CHARGING: begin
               if (s1_ipk_ff > current_lim_ff && switch_ff) begin
                  // overcurrent trip while conducting
                  switch_in = 1'b0;
                  yellow_in = 1'b0;
                  red_in    = 1'b1;
                  wait_in   = bcc_pkg::OVERCURRENT_WAIT;
                  mode_in   = bcc_pkg::MODE_OVERCURRENT;
               end else if (vbat > vset) begin
                  // battery full: hold off and count toward standby
                  switch_in = 1'b0;
                  yellow_in = 1'b0;
                  if (full_ff != 16'hFFFF) begin
                     full_in = full_ff + 16'd1;
                  end
                  if (full_in > full_hold_ff) begin
                     mode_in = bcc_pkg::MODE_STANDBY;
                  end
               end else begin
                  // fire the switch only on a fresh sync edge
                  if (sync_edge_ff) begin
                     switch_in = 1'b1;
                     yellow_in = 1'b1;
                     red_in    = 1'b0;
                  end
                  if (full_ff != '0) begin
                     full_in = full_ff - 16'd1;
                  end
               end
            end
            bcc_pkg::MODE_OVERCURRENT: begin
               if (wait_ff == '0) begin
                  mode_in = bcc_pkg::MODE_STANDBY;
                  red_in  = 1'b0;
               end
            end
            bcc_pkg::MODE_REVERSAL: begin
               if (wait_ff == '0) begin
                  if (s1_vb_ff >= reversal_lvl_ff) begin
                     err_in  = 1'b0;
                     mode_in = bcc_pkg::MODE_STANDBY;
                  end else begin
                     wait_in = reversal_ms_ff;
                  end
               end
            end
            default: ;
         endcase

         // line sync with hysteresis
         if (s1_line_ff > sync_on_ff) begin
            sync_edge_in = !sync_lvl_ff;
            sync_lvl_in  = 1'b1;
         end else if (s1_line_ff < sync_low_ff) begin
            sync_lvl_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bcc_pkg::MODE_STANDBY;
         bat_sum_ff   <= '0;
         set_sum_ff   <= '0;
         full_ff      <= '0;
         wait_ff      <= '0;
         sync_lvl_ff  <= 1'b0;
         sync_edge_ff <= 1'b0;
         switch_ff    <= 1'b0;
         yellow_ff    <= 1'b0;
         red_ff       <= 1'b0;
         err_ff       <= 1'b0;
      end else if (s1_fire) begin
         mode_ff      <= mode_in;
         bat_sum_ff   <= bat_sum_in;
         set_sum_ff   <= set_sum_in;
         full_ff      <= full_in;
         wait_ff      <= wait_in;
         sync_lvl_ff  <= sync_lvl_in;
         sync_edge_ff <= sync_edge_in;
         switch_ff    <= switch_in;
         yellow_ff    <= yellow_in;
         red_ff       <= red_in;
         err_ff       <= err_in;
      end
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ch.switch_on     <= switch_in;
         rsp_ch.sync_out      <= sync_lvl_in;
         rsp_ch.charger_state <= mode_in;
         rsp_ch.error_code    <= err_in;
         rsp_ch.charging_lamp <= yellow_in;
         rsp_ch.fault_lamp    <= red_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // red lamp only lit in the overcurrent state
   `BCC_ASSERT_IMP(a_red_in_oc, clock, reset, red_ff, mode_ff == bcc_pkg::MODE_OVERCURRENT)
   // polarity error flag tracks the reversal state
   `BCC_ASSERT_IMP(a_err_rev, clock, reset, 1'b1, err_ff == (mode_ff == bcc_pkg::MODE_REVERSAL))
   // switch conducts only while charging
   `BCC_ASSERT_IMP(a_sw_chg, clock, reset, switch_ff, mode_ff == bcc_pkg::MODE_CHARGING)
   // ring read and write never collide on one entry
   `BCC_ASSERT_IMP(a_no_collide, clock, reset, s1_wr && rd_en, s1_pos_ff != pos_ff)
   // a committed stage 1 transaction shows up at the response register
   `BCC_ASSERT_NXT(a_rsp_load, clock, reset, s1_fire, rsp_valid_ff)

endmodule
